// File: rtl/core/pdt_pkg.sv
// ---------------------------------------------------------------------------
// pdt_pkg
// Shared widths, operation codes and memory geometry for the depth table.
// ---------------------------------------------------------------------------
package pdt_pkg;

	localparam int ENTRY_INDEX_BITS = 16;

	localparam int OP_W    = 2;
	localparam int INDEX_W = 16;
	localparam int DEPTH_W = 4;

	localparam int OCT_AW = ENTRY_INDEX_BITS - 1;
	localparam int VIS_AW = ENTRY_INDEX_BITS - 3;
	localparam int BYTE_W = 8;

	localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	localparam logic [DEPTH_W-1:0] DEPTH_LIMIT_RST = 4'd1;
	localparam logic [BYTE_W-1:0]  OCT_UNKNOWN     = 8'hFF;

endpackage

// File: rtl/core/pdt_if.sv
// ---------------------------------------------------------------------------
// pdt interfaces
// Request, response and configuration channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface pdt_req_if;
	logic                          valid;
	logic                          ready;
	logic [pdt_pkg::OP_W-1:0]      operation;
	logic [pdt_pkg::INDEX_W-1:0]   entry_index;
	logic [pdt_pkg::DEPTH_W-1:0]   node_depth;

	modport source (output valid, output operation, output entry_index,
		output node_depth, input ready);
	modport sink (input valid, input operation, input entry_index,
		input node_depth, output ready);
endinterface

interface pdt_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          expand;
	logic                          updated;
	logic [pdt_pkg::DEPTH_W-1:0]   stored_depth;

	modport source (output valid, output expand, output updated,
		output stored_depth, input ready);
	modport sink (input valid, input expand, input updated,
		input stored_depth, output ready);
endinterface

interface pdt_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [pdt_pkg::DEPTH_W-1:0]   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/packed_depth_table_with_visit_map.sv
// ---------------------------------------------------------------------------
// packed_depth_table_with_visit_map
// Nibble-packed depth table and visited bitmap, both in synchronous RAM.
// ---------------------------------------------------------------------------
// After reset the block sweeps the depth RAM to 0xFF and the visit RAM to
// zero, one address a cycle, through all 2^(ENTRY_INDEX_BITS-1) = 32768
// depth addresses; req.ready stays low meanwhile (cfg writes are taken). An
// update or query first reads both RAMs into registers on acceptance, then
// computes, writes back and loads the response register, so one item is in
// flight at a time and a repeated entry always sees the previous write. A
// clear sweeps the visit RAM, one byte a cycle, then returns its beat. A
// pending response beat stalls only the item that finishes behind it; the
// next request beat is still taken once the block is idle.
module packed_depth_table_with_visit_map (
	input  logic       clk,
	input  logic       arst_n,
	pdt_cfg_if.sink    cfg,
	pdt_req_if.sink    req,
	pdt_rsp_if.source  rsp
);
	import pdt_pkg::*;

	typedef enum logic [4:0] {
		ST_INIT = 5'b00001,
		ST_IDLE = 5'b00010,
		ST_EXEC = 5'b00100,
		ST_CLR  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	logic [BYTE_W-1:0] oct_mem [0:(1 << OCT_AW)-1];
	logic [BYTE_W-1:0] vis_mem [0:(1 << VIS_AW)-1];

	logic [BYTE_W-1:0]           oct_rd_s1, vis_rd_s1;
	logic [OCT_AW-1:0]           sweep_cnt_q;
	logic [DEPTH_W-1:0]          depth_limit_q;
	logic [OP_W-1:0]             op_q;
	logic [ENTRY_INDEX_BITS-1:0] pos_q;
	logic [DEPTH_W-1:0]          depth_q;

	logic                        rsp_valid_q, expand_q, updated_q;
	logic [DEPTH_W-1:0]          stored_q;

	logic [ENTRY_INDEX_BITS-1:0] pos_d;
	logic                        accept, slot_free, finish, load;
	logic                        sweep_last_oct, sweep_last_vis;
	logic [DEPTH_W-1:0]          stored, res_stored;
	logic                        seen, upd_path, lower, res_expand;
	logic [BYTE_W-1:0]           oct_new, vis_new;

	logic                        oct_we, vis_we;
	logic [OCT_AW-1:0]           oct_wa;
	logic [VIS_AW-1:0]           vis_wa;
	logic [BYTE_W-1:0]           oct_wd, vis_wd;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign pos_d     = ENTRY_INDEX_BITS'(req.entry_index);
	assign slot_free = !rsp_valid_q || rsp.ready;

	assign sweep_last_oct = &sweep_cnt_q;
	assign sweep_last_vis = &sweep_cnt_q[VIS_AW-1:0];

	// item evaluation on registered read data
	always_comb begin
		stored   = pos_q[0] ? oct_rd_s1[7:4] : oct_rd_s1[3:0];
		seen     = vis_rd_s1[pos_q[2:0]];
		upd_path = (op_q == OP_UPDATE) && (depth_q < depth_limit_q) && (depth_q <= stored);
		lower    = upd_path && (depth_q < stored);
		res_expand = lower || (upd_path && !seen);
		res_stored = ((op_q == OP_UPDATE) || (op_q == OP_QUERY)) ? stored : '0;
		vis_new  = vis_rd_s1 | (BYTE_W'(1) << pos_q[2:0]);
		oct_new  = pos_q[0] ? {depth_q, oct_rd_s1[3:0]} : {oct_rd_s1[7:4], depth_q};
	end

	assign finish = (state_q == ST_EXEC) && (op_q != OP_CLEAR) && slot_free;
	assign load   = finish || ((state_q == ST_FIN) && slot_free);

	// RAM write port selection
	always_comb begin
		oct_we = 1'b0;
		vis_we = 1'b0;
		oct_wa = sweep_cnt_q;
		vis_wa = sweep_cnt_q[VIS_AW-1:0];
		oct_wd = OCT_UNKNOWN;
		vis_wd = '0;
		case (state_q)
			ST_INIT: begin
				oct_we = 1'b1;
				vis_we = 1'b1;
			end
			ST_CLR: begin
				vis_we = 1'b1;
			end
			ST_EXEC: begin
				oct_we = finish && lower;
				vis_we = finish && upd_path;
				oct_wa = pos_q[ENTRY_INDEX_BITS-1:1];
				vis_wa = pos_q[ENTRY_INDEX_BITS-1:3];
				oct_wd = oct_new;
				vis_wd = vis_new;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (oct_we) begin
			oct_mem[oct_wa] <= oct_wd;
		end
		if (accept) begin
			oct_rd_s1 <= oct_mem[pos_d[ENTRY_INDEX_BITS-1:1]];
		end
	end

	always_ff @(posedge clk) begin
		if (vis_we) begin
			vis_mem[vis_wa] <= vis_wd;
		end
		if (accept) begin
			vis_rd_s1 <= vis_mem[pos_d[ENTRY_INDEX_BITS-1:3]];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: if (sweep_last_oct) state_d = ST_IDLE;
			ST_IDLE: if (accept) state_d = ST_EXEC;
			ST_EXEC: begin
				if (op_q == OP_CLEAR) begin
					state_d = ST_CLR;
				end else if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_CLR:  if (sweep_last_vis) state_d = ST_FIN;
			ST_FIN:  if (slot_free) state_d = ST_IDLE;
			default: state_d = ST_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_INIT;
			sweep_cnt_q   <= '0;
			depth_limit_q <= DEPTH_LIMIT_RST;
			rsp_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT) begin
				sweep_cnt_q <= sweep_cnt_q + 1'b1;
			end else if (state_q == ST_CLR) begin
				sweep_cnt_q <= sweep_last_vis ? '0 : sweep_cnt_q + 1'b1;
			end
			if (cfg.valid && cfg.ready) begin
				depth_limit_q <= cfg.data;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// hold item fields and response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.operation;
			pos_q   <= pos_d;
			depth_q <= req.node_depth;
		end
		if (load) begin
			expand_q  <= finish && res_expand;
			updated_q <= finish && lower;
			stored_q  <= finish ? res_stored : '0;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.expand       = expand_q;
	assign rsp.updated      = updated_q;
	assign rsp.stored_depth = stored_q;

endmodule
